// ===== rtl/core/calendar_minute_advance_assert.svh =====
// Assertion helpers shared by the calendar block.
`ifndef CALENDAR_MINUTE_ADVANCE_ASSERT_SVH
`define CALENDAR_MINUTE_ADVANCE_ASSERT_SVH

// Check that cond implies prop in the same cycle, outside reset.
`define CMA_ASSERT_SAME(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("calendar assertion failed");

// Check that cond implies prop in the following cycle, outside reset.
`define CMA_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("calendar assertion failed");

`endif

// ===== rtl/core/cma_pkg.sv =====
`timescale 1ns / 1ps

package cma_pkg;

    // Operation codes
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Counter limits
    localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY  = 6'd24;
    localparam logic [4:0] MONTH_PER_YR  = 5'd12;
    localparam logic [6:0] YEAR_LAST     = 7'd99;
    localparam logic [6:0] YEAR_CENTURY  = 7'd100;
    localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [4:0] DAYS_DEFAULT  = 5'd31;
    localparam logic [3:0] MONTH_FEB     = 4'd2;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic       operation;
        logic [5:0] load_second;
        logic [5:0] load_minute;
        logic [4:0] load_hour;
        logic [4:0] load_day;
        logic [3:0] load_month;
        logic [6:0] load_year;
    } cma_in_t;

    typedef struct packed {
        logic [5:0] now_second;
        logic [5:0] now_minute;
        logic [4:0] now_hour;
        logic [4:0] now_day;
        logic [3:0] now_month;
        logic [6:0] now_year;
    } cma_out_t;

    localparam cma_out_t RESET_TIME = '{
        now_second: 6'd49,
        now_minute: 6'd59,
        now_hour:   5'd23,
        now_day:    5'd6,
        now_month:  4'd12,
        now_year:   7'd18
    };

    // Leap test on a two-digit year: multiple of four, century year excluded,
    // year zero counts as a multiple of four hundred.
    function automatic logic is_leap(input logic [6:0] year);
        return (year[1:0] == 2'b00) && (year != YEAR_CENTURY);
    endfunction

    // Days in a month; a month outside 1..12 allows 31 days.
    function automatic logic [4:0] day_limit(input logic [3:0] month,
                                             input logic [6:0] year);
        logic [3:0] idx;
        idx = month - 4'd1;
        if (month == 4'd0 || month > MONTH_PER_YR[3:0]) begin
            return DAYS_DEFAULT;
        end else if (month == MONTH_FEB && is_leap(year)) begin
            return DAYS_FEB_LEAP;
        end else begin
            return MONTH_LEN[idx];
        end
    endfunction

endpackage

// ===== rtl/core/calendar_minute_advance.sv =====
`timescale 1ns / 1ps
// Path: an accepted input word waits in the input register until the result
// register is free, then its result is registered there; two register stages in all.
// Throughput: one word per cycle while the result side does not stall; a new
// word is taken while a result waits. Timing is set by one input register and
// one result register with the minute-to-year carry chain between them.
// Reset: both stages empty, time set to 23:59:49 on day 6, month 12, year 18.
`include "calendar_minute_advance_assert.svh"

module calendar_minute_advance (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cma_pkg::cma_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output cma_pkg::cma_out_t m_payload
);
    import cma_pkg::*;

    logic     in_valid_reg;
    cma_in_t  in_reg;
    logic     out_valid_reg;
    cma_out_t out_reg;
    cma_out_t time_reg;
    cma_out_t time_next;

    logic       out_free;
    logic       step;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;

    // Move a word on when the result stage is empty or being drained
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign min_inc   = {1'b0, time_reg.now_minute} + 7'd1;
    assign hour_inc  = {1'b0, time_reg.now_hour} + 6'd1;
    assign day_inc   = {1'b0, time_reg.now_day} + 6'd1;
    assign month_inc = {1'b0, time_reg.now_month} + 5'd1;

    // Load the time or advance one minute with carries up to the year
    always_comb begin
        time_next = time_reg;
        if (in_reg.operation == OP_LOAD) begin
            time_next.now_second = in_reg.load_second;
            time_next.now_minute = in_reg.load_minute;
            time_next.now_hour   = in_reg.load_hour;
            time_next.now_day    = in_reg.load_day;
            time_next.now_month  = in_reg.load_month;
            time_next.now_year   = in_reg.load_year;
        end else begin
            time_next.now_second = '0;
            if (min_inc < MIN_PER_HOUR) begin
                time_next.now_minute = min_inc[5:0];
            end else begin
                time_next.now_minute = '0;
                if (hour_inc < HOUR_PER_DAY) begin
                    time_next.now_hour = hour_inc[4:0];
                end else begin
                    time_next.now_hour = '0;
                    if (day_inc <= {1'b0, day_limit(time_reg.now_month,
                                                    time_reg.now_year)}) begin
                        time_next.now_day = day_inc[4:0];
                    end else begin
                        time_next.now_day = 5'd1;
                        if (month_inc <= MONTH_PER_YR) begin
                            time_next.now_month = month_inc[3:0];
                        end else begin
                            time_next.now_month = 4'd1;
                            if (time_reg.now_year >= YEAR_LAST) begin
                                time_next.now_year = '0;
                            end else begin
                                time_next.now_year = time_reg.now_year + 7'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Hold control and time state, mark words and results valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            time_reg      <= RESET_TIME;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
                time_reg      <= time_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        if (step) begin
            out_reg <= time_next;
        end
    end

    `CMA_ASSERT_NEXT(a_step_gives_result, aclk, aresetn, step, out_valid_reg)
    `CMA_ASSERT_SAME(a_result_matches_time, aclk, aresetn, out_valid_reg,
                     out_reg == time_reg)
    `CMA_ASSERT_NEXT(a_advance_clears_second, aclk, aresetn,
                     step && in_reg.operation == OP_ADVANCE,
                     time_reg.now_second == 6'd0)
    `CMA_ASSERT_NEXT(a_load_takes_minute, aclk, aresetn,
                     step && in_reg.operation == OP_LOAD,
                     time_reg.now_minute == $past(in_reg.load_minute))

endmodule

// ===== test/calendar_minute_advance_tb.sv =====
`timescale 1ns / 1ps

module calendar_minute_advance_tb;
    import cma_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int STALL_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 26;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MONTHS_PER_YEAR  = 12;
    localparam int LAST_YEAR        = 99;
    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        cma_in_t  word;
        bit       known;
        cma_out_t want;
    } probe_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    cma_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    cma_out_t m_payload;

    // side band that travels with the input word: typed-in expectation
    bit       s_known   = 1'b0;
    cma_out_t s_want    = '0;

    // predicted calendar, starts at the reset time
    logic [5:0] cal_sec   = 6'd49;
    logic [5:0] cal_min   = 6'd59;
    logic [4:0] cal_hour  = 5'd23;
    logic [4:0] cal_day   = 5'd6;
    logic [3:0] cal_month = 4'd12;
    logic [6:0] cal_year  = 7'd18;

    cma_out_t due_times [$];
    cma_out_t next_time;
    int       mismatch_cnt = 0;
    int       idle_cycles  = 0;
    bit       burst_tx     = 1'b0;
    bit       burst_rx     = 1'b0;
    probe_t   plan [DIRECTED_ROWS];

    always #HALF_PERIOD aclk = ~aclk;

    calendar_minute_advance uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Days allowed in a month; an unknown month allows 31
    function automatic int month_days(int month, int year);
        bit leap;
        leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
        if (month < 1 || month > MONTHS_PER_YEAR) return 31;
        if (month == 2 && leap) return 29;
        return DAYS_IN_MONTH[month - 1];
    endfunction

    // Advance one minute: clear seconds, carry up to the year
    function void advance_calendar();
        int v;
        cal_sec = '0;
        v = int'(cal_min) + 1;
        if (v < MINUTES_PER_HOUR) begin
            cal_min = 6'(v);
            return;
        end
        cal_min = '0;
        v = int'(cal_hour) + 1;
        if (v < HOURS_PER_DAY) begin
            cal_hour = 5'(v);
            return;
        end
        cal_hour = '0;
        v = int'(cal_day) + 1;
        if (v <= month_days(int'(cal_month), int'(cal_year))) begin
            cal_day = 5'(v);
            return;
        end
        cal_day = 5'd1;
        v = int'(cal_month) + 1;
        if (v <= MONTHS_PER_YEAR) begin
            cal_month = 4'(v);
            return;
        end
        cal_month = 4'd1;
        cal_year  = (cal_year >= LAST_YEAR) ? 7'd0 : cal_year + 7'd1;
    endfunction

    // Apply one input word and return the time that follows it
    function cma_out_t apply_word(cma_in_t w);
        cma_out_t t;
        if (w.operation == OP_LOAD) begin
            cal_sec   = w.load_second;
            cal_min   = w.load_minute;
            cal_hour  = w.load_hour;
            cal_day   = w.load_day;
            cal_month = w.load_month;
            cal_year  = w.load_year;
        end else begin
            advance_calendar();
        end
        t.now_second = cal_sec;
        t.now_minute = cal_min;
        t.now_hour   = cal_hour;
        t.now_day    = cal_day;
        t.now_month  = cal_month;
        t.now_year   = cal_year;
        return t;
    endfunction

    function automatic cma_out_t clock_at(int s, int mi, int h, int d, int mo, int y);
        cma_out_t t;
        t.now_second = 6'(s);
        t.now_minute = 6'(mi);
        t.now_hour   = 5'(h);
        t.now_day    = 5'(d);
        t.now_month  = 4'(mo);
        t.now_year   = 7'(y);
        return t;
    endfunction

    function automatic probe_t load_row(int s, int mi, int h, int d, int mo, int y);
        probe_t p;
        p.word             = '0;
        p.word.operation   = OP_LOAD;
        p.word.load_second = 6'(s);
        p.word.load_minute = 6'(mi);
        p.word.load_hour   = 5'(h);
        p.word.load_day    = 5'(d);
        p.word.load_month  = 4'(mo);
        p.word.load_year   = 7'(y);
        p.known            = 1'b1;
        p.want             = clock_at(s, mi, h, d, mo, y);
        return p;
    endfunction

    function automatic probe_t advance_row(bit known, cma_out_t want);
        probe_t p;
        p.word           = '0;
        p.word.operation = OP_ADVANCE;
        p.known          = known;
        p.want           = want;
        return p;
    endfunction

    // Fully random word with the given operation
    function automatic cma_in_t random_word(logic op);
        logic [63:0] bits;
        cma_in_t     w;
        bits        = {$urandom, $urandom};
        w           = bits[$bits(cma_in_t)-1:0];
        w.operation = op;
        return w;
    endfunction

    function void report(string field, logic [6:0] want, logic [6:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_time(cma_out_t want, cma_out_t got);
        if (got.now_second !== want.now_second)
            report("second", 7'(want.now_second), 7'(got.now_second));
        if (got.now_minute !== want.now_minute)
            report("minute", 7'(want.now_minute), 7'(got.now_minute));
        if (got.now_hour   !== want.now_hour)
            report("hour",   7'(want.now_hour),   7'(got.now_hour));
        if (got.now_day    !== want.now_day)
            report("day",    7'(want.now_day),    7'(got.now_day));
        if (got.now_month  !== want.now_month)
            report("month",  7'(want.now_month),  7'(got.now_month));
        if (got.now_year   !== want.now_year)
            report("year",   want.now_year,       got.now_year);
    endfunction

    // Check result words, predict accepted input words, watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_times.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("result word with nothing pending: %p", m_payload);
                end else begin
                    check_time(due_times.pop_front(), m_payload);
                end
            end
            if (s_valid && s_ready) begin
                next_time = apply_word(s_payload);
                due_times.push_back(s_known ? s_want : next_time);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // Result side: stall a random number of cycles before each word
    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) burst_rx = !burst_rx;
            stall = burst_rx ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Present one word after a random gap and hold it until taken
    task automatic send_word(cma_in_t w, bit known = 1'b0, cma_out_t want = '0);
        int gap;
        if ($urandom_range(0, 39) == 0) burst_tx = !burst_tx;
        gap = burst_tx ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= w;
        s_known   <= known;
        s_want    <= want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold off the input side until every pending result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (due_times.size() != 0);
    endtask

    initial begin
        int      sent;
        int      runs;
        bit      paused;
        cma_in_t w;

        // directed rows: reset time, wraps, leap cases, out-of-range loads
        plan[0]  = advance_row(1'b1, clock_at(0, 0, 0, 7, 12, 18));
        plan[1]  = load_row(59, 59, 23, 31, 12, 99);
        plan[2]  = advance_row(1'b1, clock_at(0, 0, 0, 1, 1, 0));
        plan[3]  = load_row(0, 0, 0, 1, 1, 0);
        plan[4]  = advance_row(1'b1, clock_at(0, 1, 0, 1, 1, 0));
        plan[5]  = load_row(30, 59, 23, 28, 2, 0);
        plan[6]  = advance_row(1'b1, clock_at(0, 0, 0, 29, 2, 0));
        plan[7]  = advance_row(1'b0, '0);
        plan[8]  = load_row(0, 59, 23, 29, 2, 0);
        plan[9]  = advance_row(1'b1, clock_at(0, 0, 0, 1, 3, 0));
        plan[10] = load_row(0, 59, 23, 28, 2, 100);
        plan[11] = advance_row(1'b1, clock_at(0, 0, 0, 1, 3, 100));
        plan[12] = load_row(0, 59, 23, 28, 2, 1);
        plan[13] = advance_row(1'b1, clock_at(0, 0, 0, 1, 3, 1));
        plan[14] = load_row(63, 63, 31, 31, 15, 127);
        plan[15] = advance_row(1'b0, '0);
        plan[16] = load_row(0, 59, 23, 0, 0, 50);
        plan[17] = advance_row(1'b0, '0);
        plan[18] = load_row(0, 59, 23, 30, 4, 5);
        plan[19] = advance_row(1'b1, clock_at(0, 0, 0, 1, 5, 5));
        plan[20] = load_row(0, 59, 23, 31, 12, 98);
        plan[21] = advance_row(1'b1, clock_at(0, 0, 0, 1, 1, 99));
        plan[22] = load_row(0, 59, 23, 4, 13, 7);
        plan[23] = advance_row(1'b0, '0);
        plan[24] = load_row(0, 59, 23, 31, 13, 7);
        plan[25] = advance_row(1'b0, '0);

        // hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) send_word(plan[i].word, plan[i].known, plan[i].want);
        wait_drained();

        // random part: mostly loads just short of a rollover, then advances
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 99)) inside
                [0:64]: begin
                    w = random_word(OP_LOAD);
                    w.load_month = 4'($urandom_range(1, 12));
                    case ($urandom_range(0, 5))
                        0:       w.load_year = 7'd0;
                        1:       w.load_year = 7'd99;
                        2:       w.load_year = 7'd98;
                        default: w.load_year = 7'($urandom_range(0, 99));
                    endcase
                    w.load_day    = 5'(month_days(int'(w.load_month), int'(w.load_year))
                                       - int'($urandom_range(0, 2)));
                    w.load_hour   = ($urandom_range(0, 3) == 0) ?
                                    5'($urandom_range(0, 23)) : 5'd23;
                    w.load_minute = 6'($urandom_range(50, 59));
                    w.load_second = 6'($urandom_range(0, 59));
                    send_word(w);
                    sent++;
                    runs = $urandom_range(1, 24);
                end
                [65:79]: begin
                    // raw load: any bit pattern in every field
                    send_word(random_word(OP_LOAD));
                    sent++;
                    runs = $urandom_range(1, 6);
                end
                default: runs = $urandom_range(20, 80);
            endcase
            repeat (runs) begin
                send_word(random_word(OP_ADVANCE));
                sent++;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && due_times.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
